// ----- rtl/rect_obstacle_collision_check_defines.svh -----
// Assertion macros shared by the rectangle collision checker RTL.
`ifndef RECT_OBSTACLE_COLLISION_CHECK_DEFINES_SVH
`define RECT_OBSTACLE_COLLISION_CHECK_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ROC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("roc assertion failed");

// next-cycle implication, disabled in reset
`define ROC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("roc assertion failed");

`endif

// ----- rtl/roc_pkg.sv -----
// Shared types and constants for the rectangle collision checker.
package roc_pkg;

	localparam int MAX_RECTS_DEF = 64;

	localparam int MAP_HEIGHT_W = 12;
	localparam int HALF_SIZE_W  = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 12;

	localparam logic [MAP_HEIGHT_W-1:0] MAP_HEIGHT_RST = 12'd1920;
	localparam logic [HALF_SIZE_W-1:0]  HALF_SIZE_RST  = 8'd20;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE  = 2'd1;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BOX   = 2'd1;
	localparam logic [1:0] OP_POINT = 2'd2;

	// stored rectangle: edges in whole units, y already flipped
	typedef struct packed {
		logic               obs;
		logic signed [14:0] y1;
		logic signed [13:0] y0;
		logic signed [13:0] x1;
		logic signed [12:0] x0;
	} rect_entry_t;

endpackage

// ----- rtl/roc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module roc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/rect_obstacle_collision_check.sv -----
// Top level of the rectangle obstacle collision checker.
// A load's result strobes on done in the cycle after the load is accepted.
// A query scans the stored rectangles one per cycle through the table RAM's
// single read port while busy is high; done strobes once the last read has
// been compared. An empty table, or an unused opcode, answers without a scan,
// with done strobing in the cycle after the accept.
// Results are held on hit/status for exactly the cycle that done is high and
// must be captured then; nothing can hold them off.
`include "rect_obstacle_collision_check_defines.svh"

module rect_obstacle_collision_check #(
	parameter int MAX_RECTS = roc_pkg::MAX_RECTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           opcode,
	input  logic signed [12:0]                   rect_x,
	input  logic signed [12:0]                   rect_y_raw,
	input  logic [11:0]                          rect_width,
	input  logic [11:0]                          rect_height,
	input  logic                                 is_obstacle,
	input  logic signed [17:0]                   pos_x,
	input  logic signed [17:0]                   pos_y,
	output logic                                 done,
	output logic                                 hit,
	output logic                                 status,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [roc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [roc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int EW = $bits(roc_pkg::rect_entry_t);
	localparam logic [CW-1:0] FULL = CW'(MAX_RECTS);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT} state_t;

	state_t                              state_q;
	logic [roc_pkg::MAP_HEIGHT_W-1:0]    map_height_q;
	logic [roc_pkg::HALF_SIZE_W-1:0]     half_size_q;
	logic [CW-1:0]                       count_q;
	logic [CW-1:0]                       idx_q;
	logic                                strict_q;
	logic signed [20:0]                  qx_lo_q, qx_hi_q, qy_lo_q, qy_hi_q;
	logic                                hit_acc_q;
	logic                                vld_s1, last_s1;
	logic                                done_q, hit_q, status_q;

	logic                                accept, do_load, full, scan_rd, scan_last;
	roc_pkg::rect_entry_t                wr_entry, rd_entry;
	logic [EW-1:0]                       rd_raw;
	logic signed [14:0]                  y0_w;
	logic signed [19:0]                  hs;
	logic signed [20:0]                  x0s, x1s, y0s, y1s;
	logic                                match;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign hit       = hit_q;
	assign status    = status_q;

	assign accept  = start && !busy;
	assign full    = (count_q >= FULL);
	assign do_load = accept && (opcode == roc_pkg::OP_LOAD) && !full;

	// flip y on load and precompute far edges
	always_comb begin
		y0_w        = $signed({3'b000, map_height_q}) - 15'(rect_y_raw);
		wr_entry.x0 = rect_x;
		wr_entry.x1 = 14'(rect_x) + $signed({2'b00, rect_width});
		wr_entry.y0 = y0_w[13:0];
		wr_entry.y1 = y0_w + $signed({3'b000, rect_height});
		wr_entry.obs = is_obstacle;
	end

	assign scan_rd   = (state_q == S_SCAN);
	assign scan_last = scan_rd && (idx_q == count_q - CW'(1));

	roc_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_RECTS),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (do_load),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_en   (scan_rd),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_raw)
	);

	assign rd_entry = roc_pkg::rect_entry_t'(rd_raw);
	assign hs       = $signed({8'd0, half_size_q, 4'd0});

	// scale stored edges by 16, compare against the query window, count only obstacles
	always_comb begin
		x0s = $signed({{4{rd_entry.x0[12]}}, rd_entry.x0, 4'd0});
		x1s = $signed({{3{rd_entry.x1[13]}}, rd_entry.x1, 4'd0});
		y0s = $signed({{3{rd_entry.y0[13]}}, rd_entry.y0, 4'd0});
		y1s = $signed({{2{rd_entry.y1[14]}}, rd_entry.y1, 4'd0});
		if (strict_q) begin
			match = (qx_hi_q > x0s) && (qx_lo_q < x1s) &&
				(qy_hi_q > y0s) && (qy_lo_q < y1s);
		end else begin
			match = (qx_hi_q >= x0s) && (qx_lo_q <= x1s) &&
				(qy_hi_q >= y0s) && (qy_lo_q <= y1s);
		end
		match = match && rd_entry.obs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_height_q <= roc_pkg::MAP_HEIGHT_RST;
			half_size_q  <= roc_pkg::HALF_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				roc_pkg::REG_MAP_HEIGHT: map_height_q <= cfg_data;
				roc_pkg::REG_HALF_SIZE:  half_size_q  <= cfg_data[roc_pkg::HALF_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			strict_q <= (opcode == roc_pkg::OP_BOX);
			if (opcode == roc_pkg::OP_BOX) begin
				qx_lo_q <= 21'(pos_x) - 21'(hs);
				qx_hi_q <= 21'(pos_x) + 21'(hs);
				qy_lo_q <= 21'(pos_y) - 21'(hs);
				qy_hi_q <= 21'(pos_y) + 21'(hs);
			end else begin
				qx_lo_q <= 21'(pos_x);
				qx_hi_q <= 21'(pos_x);
				qy_lo_q <= 21'(pos_y);
				qy_hi_q <= 21'(pos_y);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			hit_acc_q <= 1'b0;
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			status_q  <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			status_q <= 1'b0;
			vld_s1   <= scan_rd;
			last_s1  <= scan_last;
			if (vld_s1 && match) begin
				hit_acc_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q     <= '0;
						hit_acc_q <= 1'b0;
						if (opcode == roc_pkg::OP_LOAD) begin
							done_q   <= 1'b1;
							status_q <= full;
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
						end else if ((opcode == roc_pkg::OP_BOX ||
							opcode == roc_pkg::OP_POINT) && count_q != '0) begin
							state_q <= S_SCAN;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + CW'(1);
					if (scan_last) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (last_s1) begin
						done_q  <= 1'b1;
						hit_q   <= hit_acc_q || (vld_s1 && match);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ROC_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE)
	`ROC_ASSERT_IMP(a_count_max, 1'b1, count_q <= FULL)
	`ROC_ASSERT_IMP(a_status_nohit, status_q, !hit_q)
	`ROC_ASSERT_IMP(a_scan_nonempty, state_q == S_SCAN, count_q != '0)
	`ROC_ASSERT_IMP(a_wait_last, state_q == S_WAIT, last_s1 && vld_s1)
	`ROC_ASSERT_NXT(a_last_wait, scan_last, state_q == S_WAIT)

endmodule

// ----- tb/sv/rect_obstacle_collision_check_test.sv -----
// Self-checking testbench for the rectangle obstacle collision checker.
`timescale 1ns / 1ps

module rect_obstacle_collision_check_test;

	localparam int MAX_RECTS = roc_pkg::MAX_RECTS_DEF;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS = 233;
	localparam longint POS_MAX = 131071;
	localparam longint POS_MIN = -131072;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [roc_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
	localparam logic [roc_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

	typedef struct {
		logic [1:0]         op;
		logic signed [12:0] rx;
		logic signed [12:0] ry;
		logic [11:0]        rw;
		logic [11:0]        rh;
		logic               obs;
		logic signed [17:0] px;
		logic signed [17:0] py;
	} collision_cmd_t;

	typedef struct {
		logic hit;
		logic status;
	} collision_res_t;

	typedef struct {
		collision_cmd_t cmd;
		bit             typed;
		collision_res_t res;
	} directed_row_t;

	typedef struct {
		longint x;
		longint y;
		longint w;
		longint h;
		bit     obs;
	} stored_rect_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] opcode;
	logic signed [12:0] rect_x;
	logic signed [12:0] rect_y_raw;
	logic [11:0] rect_width;
	logic [11:0] rect_height;
	logic is_obstacle;
	logic signed [17:0] pos_x;
	logic signed [17:0] pos_y;
	logic done;
	logic hit;
	logic status;
	logic cfg_valid;
	logic cfg_ready;
	logic [roc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [roc_pkg::CFG_DATA_W-1:0] cfg_data;

	stored_rect_t rect_store [MAX_RECTS];
	int unsigned stored_count;
	logic [11:0] map_h;
	logic [7:0] half_edge;
	collision_res_t pending_outcomes[$];
	int unsigned mismatches;

	rect_obstacle_collision_check #(.MAX_RECTS(MAX_RECTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.rect_x(rect_x),
		.rect_y_raw(rect_y_raw),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.is_obstacle(is_obstacle),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.done(done),
		.hit(hit),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Updates the shadow table and returns the outcome of one command.
	function automatic collision_res_t resolve_cmd(collision_cmd_t c);
		collision_res_t r;
		longint hs;
		longint px;
		longint py;
		longint x0;
		longint x1;
		longint y0;
		longint y1;
		r = '{hit: 1'b0, status: 1'b0};
		hs = longint'(half_edge) * 16;
		px = longint'(c.px);
		py = longint'(c.py);
		case (c.op)
		roc_pkg::OP_LOAD: begin
			if (stored_count >= MAX_RECTS) begin
				r.status = 1'b1;
			end else begin
				rect_store[stored_count].x = longint'(c.rx);
				rect_store[stored_count].y = longint'(map_h) - longint'(c.ry);
				rect_store[stored_count].w = longint'(c.rw);
				rect_store[stored_count].h = longint'(c.rh);
				rect_store[stored_count].obs = c.obs;
				stored_count++;
			end
		end
		roc_pkg::OP_BOX, roc_pkg::OP_POINT: begin
			for (int i = 0; i < stored_count; i++) begin
				x0 = rect_store[i].x * 16;
				x1 = (rect_store[i].x + rect_store[i].w) * 16;
				y0 = rect_store[i].y * 16;
				y1 = (rect_store[i].y + rect_store[i].h) * 16;
				if (!rect_store[i].obs)
					continue;
				if (c.op == roc_pkg::OP_BOX) begin
					if (px + hs > x0 && px - hs < x1 && py + hs > y0 && py - hs < y1)
						r.hit = 1'b1;
				end else begin
					if (px >= x0 && px <= x1 && py >= y0 && py <= y1)
						r.hit = 1'b1;
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic collision_cmd_t load_cmd(int x, int y, int w, int h, bit o);
		collision_cmd_t c;
		c.op = roc_pkg::OP_LOAD;
		c.rx = 13'(x);
		c.ry = 13'(y);
		c.rw = 12'(w);
		c.rh = 12'(h);
		c.obs = o;
		c.px = 18'($urandom());
		c.py = 18'($urandom());
		return c;
	endfunction

	function automatic collision_cmd_t query_cmd(logic [1:0] op, int px, int py);
		collision_cmd_t c;
		c.op = op;
		c.rx = 13'($urandom());
		c.ry = 13'($urandom());
		c.rw = 12'($urandom());
		c.rh = 12'($urandom());
		c.obs = 1'($urandom());
		c.px = 18'(px);
		c.py = 18'(py);
		return c;
	endfunction

	function automatic logic signed [17:0] to_pos(longint v);
		if (v > POS_MAX)
			v = POS_MAX;
		else if (v < POS_MIN)
			v = POS_MIN;
		return v[17:0];
	endfunction

	// near the low edge, near the high edge, or anywhere in between
	function automatic longint aim_near(longint lo, longint hi, longint spread);
		case ($urandom_range(0, 2))
		0: return lo + longint'($urandom_range(0, 32'(2 * spread))) - spread;
		1: return hi + longint'($urandom_range(0, 32'(2 * spread))) - spread;
		default: return lo + longint'($urandom_range(0, 32'(hi - lo)));
		endcase
	endfunction

	function automatic collision_cmd_t random_cmd();
		collision_cmd_t c;
		int roll;
		int i;
		longint spread;
		c = query_cmd(2'($urandom_range(roc_pkg::OP_BOX, roc_pkg::OP_POINT)),
			int'($urandom()), int'($urandom()));
		roll = int'($urandom_range(0, 99));
		if (roll < 8) begin
			c.op = roc_pkg::OP_LOAD;
			if ($urandom_range(0, 9) != 0) begin
				c.rx = 13'(int'($urandom_range(0, 800)) - 400);
				c.ry = 13'(int'($urandom_range(0, 2400)) - 300);
				c.rw = 12'($urandom_range(0, 255));
				c.rh = 12'($urandom_range(0, 255));
			end
			c.obs = $urandom_range(0, 3) != 0;
		end else if (roll < 12) begin
			c.op = OP_UNUSED;
		end else if (roll >= 28 && stored_count != 0) begin
			i = int'($urandom_range(0, stored_count - 1));
			spread = (c.op == roc_pkg::OP_BOX ? longint'(half_edge) * 16 : 0) + 24;
			c.px = to_pos(aim_near(rect_store[i].x * 16,
				(rect_store[i].x + rect_store[i].w) * 16, spread));
			c.py = to_pos(aim_near(rect_store[i].y * 16,
				(rect_store[i].y + rect_store[i].h) * 16, spread));
		end
		return c;
	endfunction

	// Called in the step of the previous accept, so start gets one update per step.
	task automatic issue_cmd(input collision_cmd_t c, input int gap, input bit drain,
		input bit typed, input collision_res_t typed_res);
		collision_res_t predicted;
		if (gap > 0 || (drain && pending_outcomes.size() != 0)) begin
			start <= 1'b0;
			while (drain && pending_outcomes.size() != 0)
				@(posedge clk);
			repeat (gap) @(posedge clk);
		end
		opcode <= c.op;
		rect_x <= c.rx;
		rect_y_raw <= c.ry;
		rect_width <= c.rw;
		rect_height <= c.rh;
		is_obstacle <= c.obs;
		pos_x <= c.px;
		pos_y <= c.py;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predicted = resolve_cmd(c);
		pending_outcomes.insert(pending_outcomes.size(), typed ? typed_res : predicted);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// unused index goes in the middle and must not disturb either register
	task automatic write_regs(input logic [11:0] map_val, input logic [11:0] half_val,
		input logic [1:0] junk_idx, input logic [11:0] junk_val);
		logic [1:0] idx [3];
		logic [11:0] val [3];
		idx = '{roc_pkg::REG_MAP_HEIGHT, junk_idx, roc_pkg::REG_HALF_SIZE};
		val = '{map_val, junk_val, half_val};
		for (int k = 0; k < 3; k++) begin
			cfg_index <= idx[k];
			cfg_data <= val[k];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			if (idx[k] == roc_pkg::REG_MAP_HEIGHT)
				map_h = val[k];
			else if (idx[k] == roc_pkg::REG_HALF_SIZE)
				half_edge = val[k][7:0];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		collision_res_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				note_mismatch($sformatf("unexpected beat hit=%0b status=%0b", hit, status));
			end else begin
				want = pending_outcomes.pop_front();
				if (hit !== want.hit || status !== want.status)
					note_mismatch($sformatf("expected hit=%0b status=%0b, got hit=%0b status=%0b",
						want.hit, want.status, hit, status));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		directed_row_t rows[$];
		collision_res_t quiet;
		bit no_idle;
		int gap;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = roc_pkg::OP_LOAD;
		rect_x = '0;
		rect_y_raw = '0;
		rect_width = '0;
		rect_height = '0;
		is_obstacle = 1'b0;
		pos_x = '0;
		pos_y = '0;
		cfg_valid = 1'b0;
		cfg_index = roc_pkg::REG_MAP_HEIGHT;
		cfg_data = '0;
		stored_count = 0;
		map_h = roc_pkg::MAP_HEIGHT_RST;
		half_edge = roc_pkg::HALF_SIZE_RST;
		mismatches = 0;
		quiet = '{hit: 1'b0, status: 1'b0};
		no_idle = 1'b0;

		// empty table, unused opcode, extreme loads, edges inclusive vs strict
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_BOX, 131071, 131071), 1'b1, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_POINT, -131072, -131072), 1'b1, quiet});
		rows.insert(rows.size(), '{query_cmd(OP_UNUSED, 131071, -131072), 1'b1, quiet});
		rows.insert(rows.size(), '{load_cmd(-4096, 4095, 4095, 4095, 1'b1), 1'b1, quiet});
		rows.insert(rows.size(), '{load_cmd(4095, -4096, 0, 0, 1'b0), 1'b1, quiet});
		rows.insert(rows.size(), '{load_cmd(100, 1820, 10, 10, 1'b1), 1'b1, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_POINT, 1600, 1600), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_POINT, 1760, 1760), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_POINT, 1761, 1700), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_BOX, 1280, 1700), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_BOX, 1281, 1700), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_BOX, 2080, 1700), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_POINT, -16, 30720), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_POINT, -15, 30721), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_POINT, 65520, 96256), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_BOX, 65520, 96256), 1'b0, quiet});
		rows.insert(rows.size(), '{load_cmd(-1, -1, 0, 0, 1'b1), 1'b1, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_POINT, -16, 30736), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_BOX, 284, 30736), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_POINT, 131071, -131072), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(roc_pkg::OP_BOX, -131072, 131071), 1'b0, quiet});
		rows.insert(rows.size(), '{query_cmd(OP_UNUSED, -131072, 131071), 1'b1, quiet});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(roc_pkg::MAP_HEIGHT_RST, {4'd0, roc_pkg::HALF_SIZE_RST}, REG_UNUSED_LO,
			12'($urandom()));
		foreach (rows[r])
			issue_cmd(rows[r].cmd, $urandom_range(0, 9), 1'b0, rows[r].typed, rows[r].res);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
			0: write_regs(12'd0, 12'd0, REG_UNUSED_HI, 12'($urandom()));
			1: write_regs(12'hFFF, 12'hFFF, REG_UNUSED_LO, 12'hFFF);
			default: write_regs(12'($urandom()), 12'($urandom_range(0, 255)), REG_UNUSED_HI,
				12'($urandom()));
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 40 == 0)
					no_idle = $urandom_range(0, 2) == 0;
				gap = no_idle ? 0 : int'($urandom_range(0, 9));
				issue_cmd(random_cmd(), gap, $urandom_range(0, 39) == 0, 1'b0, quiet);
			end
			settle();
		end

		repeat (MAX_RECTS + 4) @(posedge clk);
		if (pending_outcomes.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
